@@ rtl/hd44780_nibble_sequencer_core_defines.svh @@
// Assertion macros for the HD44780 nibble sequencer.
// No dependencies; included by the top level.
`ifndef HD44780_NIBBLE_SEQUENCER_CORE_DEFINES_SVH
`define HD44780_NIBBLE_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define HNS_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define HNS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/hns_pkg.sv @@
// Package for the HD44780 nibble sequencer: types, register codes, LCD constants.
// No dependencies.
`timescale 1ns / 1ps

package hns_pkg;

  localparam int QUEUE_DEPTH = 2;

  localparam int STEP_W     = 4;
  localparam int INIT_STEPS = 12;
  localparam logic [STEP_W-1:0] INIT_LAST      = STEP_W'(INIT_STEPS - 1);
  localparam logic [STEP_W-1:0] BYTE_LAST      = STEP_W'(1);
  localparam logic [STEP_W-1:0] STEP_FIRST     = '0;
  localparam logic [STEP_W-1:0] STEP_CLEAR_LOW = STEP_W'(9);

  localparam logic [1:0] MODE_INIT = 2'd0;
  localparam logic [1:0] MODE_CMD  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;
  localparam logic [1:0] MODE_ROW  = 2'd3;

  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_HOME       = 8'h02;
  localparam logic [7:0] CMD_ENTRY      = 8'h06;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [7:0] ROW2_ADDR      = 8'h40;
  localparam logic [3:0] INIT_NIB       = 4'h3;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_COMMAND = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_ON     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_FIRST   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_NEXT    = 3'd5;

  localparam logic [7:0]  RST_ENABLE_HIGH  = 8'd1;
  localparam logic [9:0]  RST_SETTLE       = 10'd100;
  localparam logic [15:0] RST_LONG_COMMAND = 16'd2000;
  localparam logic [15:0] RST_POWER_ON     = 16'd50000;
  localparam logic [13:0] RST_INIT_FIRST   = 14'd5000;
  localparam logic [9:0]  RST_INIT_NEXT    = 10'd150;

  typedef struct packed {
    logic [7:0]  enable_high_us;
    logic [9:0]  settle_us;
    logic [15:0] long_command_us;
    logic [15:0] power_on_us;
    logic [13:0] init_first_us;
    logic [9:0]  init_next_us;
  } cfg_t;

  typedef struct packed {
    logic       init;
    logic       rs;
    logic [7:0] cmd_byte;
  } item_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } q_wr_t;

  typedef struct packed {
    logic  vld;
    item_t item;
  } q_rd_t;

  typedef struct packed {
    logic              busy;
    logic              init;
    logic              fire;
    logic              last;
    logic [STEP_W-1:0] step;
  } bk_stat_t;

  function automatic logic [3:0] init_nibble(input logic [STEP_W-1:0] step);
    logic [3:0] nib;
    case (step)
      4'd0, 4'd1, 4'd2: nib = INIT_NIB;
      4'd3:             nib = 4'h2;
      4'd4:             nib = CMD_FUNC_4BIT[7:4];
      4'd5:             nib = CMD_FUNC_4BIT[3:0];
      4'd6:             nib = CMD_DISPLAY_ON[7:4];
      4'd7:             nib = CMD_DISPLAY_ON[3:0];
      4'd8:             nib = CMD_CLEAR[7:4];
      4'd9:             nib = CMD_CLEAR[3:0];
      4'd10:            nib = CMD_ENTRY[7:4];
      4'd11:            nib = CMD_ENTRY[3:0];
      default:          nib = 4'h0;
    endcase
    return nib;
  endfunction

endpackage

@@ rtl/hns_req_if.sv @@
// Request channel: one LCD request per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface hns_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] value;
  logic       row;

  modport source (output valid, output mode, output value, output row, input ready);
  modport sink   (input valid, input mode, input value, input row, output ready);
endinterface

@@ rtl/hns_pulse_if.sv @@
// Pulse channel: one enable pulse description per transfer.
// Depends on nothing.
`timescale 1ns / 1ps

interface hns_pulse_if;
  logic        valid;
  logic        ready;
  logic        rs;
  logic [3:0]  nibble;
  logic [15:0] wait_before_us;
  logic [7:0]  pulse_us;
  logic [16:0] wait_after_us;
  logic        last;

  modport source (output valid, output rs, output nibble, output wait_before_us,
                  output pulse_us, output wait_after_us, output last, input ready);
  modport sink   (input valid, input rs, input nibble, input wait_before_us,
                  input pulse_us, input wait_after_us, input last, output ready);
endinterface

@@ rtl/hns_cfg_if.sv @@
// Configuration write channel: register index and write data.
// Depends on hns_pkg.
`timescale 1ns / 1ps

interface hns_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [hns_pkg::CFG_IDX_W-1:0]    index;
  logic [hns_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/hns_front.sv @@
// Front end: accepts requests and reduces them to an init flag, rs and a byte.
// Depends on hns_pkg, hns_req_if.
`timescale 1ns / 1ps

module hns_front (
  input  logic           clk,
  input  logic           rst,
  hns_req_if.sink        req,
  output hns_pkg::q_wr_t wr,
  input  logic           wr_ready
);

  logic           vld;
  hns_pkg::item_t item;
  hns_pkg::item_t item_next;

  always_comb begin
    item_next = '0;
    case (req.mode)
      hns_pkg::MODE_INIT: begin
        item_next.init = 1'b1;
      end
      hns_pkg::MODE_CMD: begin
        item_next.cmd_byte = req.value;
      end
      hns_pkg::MODE_DATA: begin
        item_next.rs       = 1'b1;
        item_next.cmd_byte = req.value;
      end
      hns_pkg::MODE_ROW: begin
        item_next.cmd_byte = hns_pkg::CMD_SET_DDRAM | (req.row ? hns_pkg::ROW2_ADDR : 8'h00);
      end
      default: item_next = '0;
    endcase
  end

  assign req.ready = !vld || wr_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (req.ready) begin
      vld <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      item <= item_next;
    end
  end

  assign wr.vld  = vld;
  assign wr.item = item;

endmodule

@@ rtl/hns_queue.sv @@
// Short queue of classified requests between front and back ends.
// Depends on hns_pkg.
`timescale 1ns / 1ps

module hns_queue #(
  parameter int DEPTH = hns_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  hns_pkg::q_wr_t wr,
  output logic           wr_ready,
  output hns_pkg::q_rd_t rd,
  input  logic           pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  hns_pkg::item_t   mem [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             take;

  assign wr_ready = count != CNT_FULL;
  assign push     = wr.vld && wr_ready;
  assign take     = pop && (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTR_LAST) ? '0 : wptr + PTR_W'(1);
      end
      if (take) begin
        rptr <= (rptr == PTR_LAST) ? '0 : rptr + PTR_W'(1);
      end
      if (push && !take) begin
        count <= count + CNT_W'(1);
      end else if (take && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr.item;
    end
  end

  assign rd.vld  = count != '0;
  assign rd.item = mem[rptr];

endmodule

@@ rtl/hns_back.sv @@
// Back end: steps through the pulses of the head request into an output
// register, one per cycle unless stalled. Depends on hns_pkg, hns_pulse_if.
`timescale 1ns / 1ps

module hns_back (
  input  logic              clk,
  input  logic              rst,
  input  hns_pkg::cfg_t     cfg,
  input  hns_pkg::q_rd_t    rd,
  output logic              pop,
  output hns_pkg::bk_stat_t stat,
  hns_pulse_if.source       pulse
);

  logic [hns_pkg::STEP_W-1:0] step;
  logic [hns_pkg::STEP_W-1:0] step_next;
  logic                       fire;
  logic                       last_step;
  logic                       rs_c;
  logic [3:0]                 nib_c;
  logic [15:0]                extra_c;
  logic [15:0]                before_c;
  logic [7:0]                 pulse_c;
  logic [16:0]                after_c;
  logic                       out_vld;

  assign fire      = rd.vld && (!out_vld || pulse.ready);
  assign last_step = rd.item.init ? (step == hns_pkg::INIT_LAST)
                                  : (step == hns_pkg::BYTE_LAST);
  assign pop       = fire && last_step;
  assign step_next = last_step ? '0 : step + hns_pkg::STEP_W'(1);

  always_comb begin
    rs_c     = !rd.item.init && rd.item.rs;
    nib_c    = step[0] ? rd.item.cmd_byte[3:0] : rd.item.cmd_byte[7:4];
    extra_c  = '0;
    before_c = '0;
    if (rd.item.init) begin
      nib_c = hns_pkg::init_nibble(step);
      if (step == hns_pkg::STEP_FIRST) begin
        before_c = cfg.power_on_us;
      end
      case (step) inside
        hns_pkg::STEP_FIRST:     extra_c = {2'b00, cfg.init_first_us};
        [4'd1:4'd3]:             extra_c = {6'd0, cfg.init_next_us};
        hns_pkg::STEP_CLEAR_LOW: extra_c = cfg.long_command_us;
        default:                 extra_c = '0;
      endcase
    end else if (step == hns_pkg::BYTE_LAST && !rd.item.rs &&
                 (rd.item.cmd_byte == hns_pkg::CMD_CLEAR ||
                  rd.item.cmd_byte == hns_pkg::CMD_HOME)) begin
      extra_c = cfg.long_command_us;
    end
    pulse_c = (cfg.enable_high_us == '0) ? 8'd1 : cfg.enable_high_us;
    after_c = {7'd0, cfg.settle_us} + {1'b0, extra_c};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= '0;
      out_vld <= 1'b0;
    end else begin
      if (fire) begin
        step <= step_next;
      end
      if (fire) begin
        out_vld <= 1'b1;
      end else if (pulse.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pulse.rs             <= rs_c;
      pulse.nibble         <= nib_c;
      pulse.wait_before_us <= before_c;
      pulse.pulse_us       <= pulse_c;
      pulse.wait_after_us  <= after_c;
      pulse.last           <= last_step;
    end
  end

  assign pulse.valid = out_vld;

  assign stat.busy = rd.vld;
  assign stat.init = rd.item.init;
  assign stat.fire = fire;
  assign stat.last = last_step;
  assign stat.step = step;

endmodule

@@ rtl/hd44780_nibble_sequencer_core.sv @@
// HD44780 4-bit interface nibble sequencer, top level.
// Depends on hns_pkg, the channel interfaces, hns_front, hns_queue, hns_back
// and hd44780_nibble_sequencer_core_defines.svh.
//
// Usage:
//   req   : one LCD request (mode, value, row) per transfer.
//   pulse : one enable pulse per transfer (rs, nibble, waits, last).
//   cfg   : register writes (index, data), always ready; write only when idle.
// A request becomes 12 pulses (init) or 2 pulses (command, data, set row),
// one pulse per cycle from the back end while the pulse receiver does not
// stall; a request passes the front register, the queue and the pulse
// register, in that order, before its first pulse is shown.
// The front end and a QUEUE_DEPTH-entry queue keep taking requests while
// the back end is busy or the pulse receiver stalls; a stall holds the
// pulse register and the step counter, and backs up into req.ready once
// the queue is full. Reset empties the queue, clears the pulse valid flag
// and loads the registers with their power-on values; no clearing pass.
`timescale 1ns / 1ps
`include "hd44780_nibble_sequencer_core_defines.svh"

module hd44780_nibble_sequencer_core #(
  parameter int QUEUE_DEPTH = hns_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  hns_req_if.sink     req,
  hns_pulse_if.source pulse,
  hns_cfg_if.sink     cfg
);

  hns_pkg::cfg_t     regs;
  hns_pkg::q_wr_t    q_wr;
  hns_pkg::q_rd_t    q_rd;
  hns_pkg::bk_stat_t bk_stat;
  logic              q_wr_ready;
  logic              q_pop;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enable_high_us  <= hns_pkg::RST_ENABLE_HIGH;
      regs.settle_us       <= hns_pkg::RST_SETTLE;
      regs.long_command_us <= hns_pkg::RST_LONG_COMMAND;
      regs.power_on_us     <= hns_pkg::RST_POWER_ON;
      regs.init_first_us   <= hns_pkg::RST_INIT_FIRST;
      regs.init_next_us    <= hns_pkg::RST_INIT_NEXT;
    end else if (cfg.valid) begin
      case (cfg.index)
        hns_pkg::REG_ENABLE_HIGH:  regs.enable_high_us  <= cfg.data[7:0];
        hns_pkg::REG_SETTLE:       regs.settle_us       <= cfg.data[9:0];
        hns_pkg::REG_LONG_COMMAND: regs.long_command_us <= cfg.data;
        hns_pkg::REG_POWER_ON:     regs.power_on_us     <= cfg.data;
        hns_pkg::REG_INIT_FIRST:   regs.init_first_us   <= cfg.data[13:0];
        hns_pkg::REG_INIT_NEXT:    regs.init_next_us    <= cfg.data[9:0];
        default: ;
      endcase
    end
  end

  hns_front u_front (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .wr       (q_wr),
    .wr_ready (q_wr_ready)
  );

  hns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (q_wr),
    .wr_ready (q_wr_ready),
    .rd       (q_rd),
    .pop      (q_pop)
  );

  hns_back u_back (
    .clk   (clk),
    .rst   (rst),
    .cfg   (regs),
    .rd    (q_rd),
    .pop   (q_pop),
    .stat  (bk_stat),
    .pulse (pulse)
  );

  `HNS_ASSERT_SAME(a_step_range, clk, rst, 1'b1, bk_stat.step <= hns_pkg::INIT_LAST, "step out of range")
  `HNS_ASSERT_SAME(a_byte_steps, clk, rst, bk_stat.busy && !bk_stat.init, bk_stat.step <= hns_pkg::BYTE_LAST, "byte request past two pulses")
  `HNS_ASSERT_NEXT(a_step_wrap, clk, rst, bk_stat.fire && bk_stat.last, bk_stat.step == hns_pkg::STEP_FIRST, "step not cleared after last pulse")

endmodule
